// ----- rtl/slcfr_pkg.sv -----
// Package with the shared types, codes and CRC function of the frame receiver.
`default_nettype none
package slcfr_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;
	localparam logic [15:0] SYNC_WORD_RST = 16'hFFFF;
	localparam logic [10:0] MAX_LENGTH_RST = 11'd2038;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [7:0] CMD_OVERRIDE = 8'hC4;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_WORD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd1;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_BODY,
		PH_TRAILER
	} phase_t;

	typedef enum logic [1:0] {
		ST_CRC_GOOD = 2'd0,
		ST_CRC_BAD = 2'd1,
		ST_LEN_ERR = 2'd2
	} status_t;

	typedef struct packed {
		status_t status;
		logic [31:0] length;
		logic [7:0] command;
		logic [15:0] rx_crc;
		logic [15:0] calc_crc;
	} frame_result_t;

	typedef struct packed {
		logic [15:0] sync_word;
		logic [10:0] max_length;
	} cfg_regs_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sync_length_crc_frame_receiver.sv -----
// Top level of the sync, length and CRC framed byte-stream receiver.
// Usage:
//   Received bytes enter on the input channel (in_valid, in_ready, rx_byte), one per beat.
//   The block hunts for the sync word, reads a big-endian length at frame offsets 5 to 8,
//   runs CRC-16/X-25 over offsets 2 to length+7 and checks it against the trailer.
//   One result beat leaves on the output channel (out_valid, out_ready and the result
//   fields) at the last trailer byte, or after offset 8 when the length is zero or too large.
//   Throughput is one byte per cycle unless the output stalls; the byte is parsed in the
//   cycle it is accepted; the registered result appears in the cycle after the last byte.
//   The rate is set by the combinational CRC byte update and the offset compare.
//   While a result waits and out_ready is low, in_ready is low; otherwise bytes flow on.
//   Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always taken;
//   index 0 sets the sync word, index 1 the largest length, other indexes are ignored.
//   Reset returns the parser to the hunt with no previous byte, clears out_valid, and
//   restores the sync word to 0xFFFF and the largest length to 2038.
`default_nettype none
module sync_length_crc_frame_receiver #(
	parameter int unsigned MAX_FRAME_BYTES = slcfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] frame_status,
	output logic [31:0] frame_length,
	output logic [7:0] command_code,
	output logic [15:0] received_crc,
	output logic [15:0] computed_crc,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [slcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [15:0] cfg_data
);

	slcfr_pkg::cfg_regs_t cfg_q;
	slcfr_pkg::frame_result_t res_d, res_q;
	logic out_valid_q;
	logic beat;
	logic emit;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign beat = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word <= slcfr_pkg::SYNC_WORD_RST;
			cfg_q.max_length <= slcfr_pkg::MAX_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				slcfr_pkg::CFG_SYNC_WORD: cfg_q.sync_word <= cfg_data;
				slcfr_pkg::CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	slcfr_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.beat(beat),
		.rx_byte(rx_byte),
		.cfg(cfg_q),
		.emit(emit),
		.result(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_status = res_q.status;
	assign frame_length = res_q.length;
	assign command_code = res_q.command;
	assign received_crc = res_q.rx_crc;
	assign computed_crc = res_q.calc_crc;

endmodule
`default_nettype wire

// ----- rtl/slcfr_parser.sv -----
// Frame parser: sync hunt, header, body and trailer tracking with CRC and result build.
`default_nettype none
module slcfr_parser #(
	parameter int unsigned MAX_FRAME_BYTES = slcfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic beat,
	input wire logic [7:0] rx_byte,
	input wire slcfr_pkg::cfg_regs_t cfg,
	output logic emit,
	output slcfr_pkg::frame_result_t result
);

	localparam int unsigned OW = $clog2(MAX_FRAME_BYTES);
	localparam logic [31:0] LEN_CAP = 32'(MAX_FRAME_BYTES - 10);
	localparam logic [OW-1:0] OFF_SYNC = OW'(2);
	localparam logic [OW-1:0] OFF_LEN_FIRST = OW'(5);
	localparam logic [OW-1:0] OFF_LEN_LAST = OW'(8);
	localparam logic [OW-1:0] OFF_CMD = OW'(32);
	localparam logic [OW-1:0] OFF_CMD_ALT = OW'(33);
	localparam logic [OW-1:0] BODY_END_ADD = OW'(7);
	localparam logic [OW-1:0] FRAME_END_ADD = OW'(9);

	slcfr_pkg::phase_t phase_q, phase_d;
	logic prev_valid_q, prev_valid_d;
	logic [7:0] last_byte_q, last_byte_d;
	logic [OW-1:0] offset_q, offset_d;
	logic [31:0] len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0] cmd_q, cmd_d;
	logic [15:0] tcrc_q, tcrc_d;

	logic [OW-1:0] len_lo;
	logic [31:0] limit;
	logic [15:0] crc_next;
	logic [7:0] cmd_next;

	assign len_lo = len_q[OW-1:0];
	assign limit = ({21'd0, cfg.max_length} > LEN_CAP) ? LEN_CAP : {21'd0, cfg.max_length};
	assign crc_next = slcfr_pkg::crc_byte(crc_q, rx_byte);
	assign cmd_next = (offset_q == OFF_CMD) ? rx_byte :
		((offset_q == OFF_CMD_ALT && rx_byte == slcfr_pkg::CMD_OVERRIDE) ?
		slcfr_pkg::CMD_OVERRIDE : cmd_q);

	always_comb begin
		phase_d = phase_q;
		prev_valid_d = prev_valid_q;
		last_byte_d = last_byte_q;
		offset_d = offset_q;
		len_d = len_q;
		crc_d = crc_q;
		cmd_d = cmd_q;
		tcrc_d = tcrc_q;
		emit = 1'b0;
		result.status = slcfr_pkg::ST_LEN_ERR;
		result.length = len_q;
		result.command = 8'd0;
		result.rx_crc = 16'd0;
		result.calc_crc = 16'd0;
		if (beat) begin
			case (phase_q)
				slcfr_pkg::PH_HUNT: begin
					if (prev_valid_q && {last_byte_q, rx_byte} == cfg.sync_word) begin
						phase_d = slcfr_pkg::PH_HEADER;
						offset_d = OFF_SYNC;
						len_d = 32'd0;
						crc_d = slcfr_pkg::CRC_INIT;
						cmd_d = 8'd0;
						tcrc_d = 16'd0;
						prev_valid_d = 1'b0;
					end else begin
						last_byte_d = rx_byte;
						prev_valid_d = 1'b1;
					end
				end
				slcfr_pkg::PH_HEADER: begin
					crc_d = crc_next;
					offset_d = offset_q + OW'(1);
					if (offset_q >= OFF_LEN_FIRST) begin
						len_d = {len_q[23:0], rx_byte};
					end
					if (offset_q >= OFF_LEN_LAST) begin
						if (len_d == 32'd0 || len_d > limit) begin
							emit = 1'b1;
							result.length = len_d;
							phase_d = slcfr_pkg::PH_HUNT;
							prev_valid_d = 1'b0;
							offset_d = offset_q;
						end else if (len_d == 32'd1) begin
							phase_d = slcfr_pkg::PH_TRAILER;
						end else begin
							phase_d = slcfr_pkg::PH_BODY;
						end
					end
				end
				slcfr_pkg::PH_BODY: begin
					crc_d = crc_next;
					cmd_d = cmd_next;
					offset_d = offset_q + OW'(1);
					if (offset_q >= len_lo + BODY_END_ADD) begin
						phase_d = slcfr_pkg::PH_TRAILER;
					end
				end
				slcfr_pkg::PH_TRAILER: begin
					cmd_d = cmd_next;
					tcrc_d = {tcrc_q[7:0], rx_byte};
					if (offset_q >= len_lo + FRAME_END_ADD) begin
						emit = 1'b1;
						result.status = ((crc_q ^ slcfr_pkg::CRC_XOROUT) == tcrc_d) ?
							slcfr_pkg::ST_CRC_GOOD : slcfr_pkg::ST_CRC_BAD;
						result.command = cmd_d;
						result.rx_crc = tcrc_d;
						result.calc_crc = crc_q ^ slcfr_pkg::CRC_XOROUT;
						phase_d = slcfr_pkg::PH_HUNT;
						prev_valid_d = 1'b0;
					end else begin
						offset_d = offset_q + OW'(1);
					end
				end
				default: begin
					phase_d = slcfr_pkg::PH_HUNT;
					prev_valid_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slcfr_pkg::PH_HUNT;
			prev_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			prev_valid_q <= prev_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		last_byte_q <= last_byte_d;
		offset_q <= offset_d;
		len_q <= len_d;
		crc_q <= crc_d;
		cmd_q <= cmd_d;
		tcrc_q <= tcrc_d;
	end

	a_emit_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (phase_q == slcfr_pkg::PH_HUNT) && !prev_valid_q)
		else $error("Frame result was not followed by a fresh sync hunt.");

	a_header_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == slcfr_pkg::PH_HEADER) |-> (offset_q >= OFF_SYNC) && (offset_q <= OFF_LEN_LAST))
		else $error("Header offset left the header window.");

	a_frame_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == slcfr_pkg::PH_BODY || phase_q == slcfr_pkg::PH_TRAILER) |->
		(offset_q <= len_lo + FRAME_END_ADD) && (len_q != 32'd0) && (len_q <= LEN_CAP))
		else $error("Frame offset ran past the frame end or length is out of range.");

	a_sync_starts_header: assert property (@(posedge clk) disable iff (!arst_n)
		(beat && phase_q == slcfr_pkg::PH_HUNT && prev_valid_q &&
		{last_byte_q, rx_byte} == cfg.sync_word) |=>
		(phase_q == slcfr_pkg::PH_HEADER) && (offset_q == OFF_SYNC) && (crc_q == slcfr_pkg::CRC_INIT))
		else $error("Sync match did not start a frame header.");

endmodule
`default_nettype wire
